@@ rtl/csrc_pkg.sv @@
// ----------------------------------------------------------------------------
// csrc_pkg
// Shared types and constants of the carrier status report checker.
// ----------------------------------------------------------------------------
package csrc_pkg;

    localparam int WORD_W   = 16;
    localparam int CAR_W    = 4;
    localparam int COUNT_W  = 8;
    localparam int REASON_W = 4;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int NUM_REGS   = 8;

    // Lowest carrier number accepted; config state limit.
    localparam logic [WORD_W-1:0] CARRIER_MIN      = WORD_W'(1);
    localparam logic [WORD_W-1:0] CONFIG_STATE_MAX = WORD_W'(2);

    // Register indexes (byte address = 4 * index).
    localparam logic [2:0] REG_CARRIER_MAX     = 3'd0;
    localparam logic [2:0] REG_ALARM_COUNT_MAX = 3'd1;
    localparam logic [2:0] REG_ALARM_CODE_MIN  = 3'd2;
    localparam logic [2:0] REG_ALARM_CODE_MAX  = 3'd3;
    localparam logic [2:0] REG_ERROR_COUNT_MAX = 3'd4;
    localparam logic [2:0] REG_ERROR_CODE_MIN  = 3'd5;
    localparam logic [2:0] REG_ERROR_CODE_MAX  = 3'd6;
    localparam logic [2:0] REG_CARD_COUNT_MAX  = 3'd7;

    // Fail reason codes.
    localparam logic [REASON_W-1:0] RSN_NONE        = 4'd0;
    localparam logic [REASON_W-1:0] RSN_COUNT       = 4'd1;
    localparam logic [REASON_W-1:0] RSN_CARRIER_NO  = 4'd2;
    localparam logic [REASON_W-1:0] RSN_CONFIG      = 4'd3;
    localparam logic [REASON_W-1:0] RSN_ALARM_COUNT = 4'd4;
    localparam logic [REASON_W-1:0] RSN_ALARM_CODE  = 4'd5;
    localparam logic [REASON_W-1:0] RSN_ERROR_COUNT = 4'd6;
    localparam logic [REASON_W-1:0] RSN_ERROR_CODE  = 4'd7;
    localparam logic [REASON_W-1:0] RSN_CARD_COUNT  = 4'd8;

    // Check limits, from the register block to the parser.
    typedef struct packed {
        logic [CAR_W-1:0]   carrier_max;
        logic [COUNT_W-1:0] alarm_count_max;
        logic [WORD_W-1:0]  alarm_code_min;
        logic [WORD_W-1:0]  alarm_code_max;
        logic [COUNT_W-1:0] error_count_max;
        logic [WORD_W-1:0]  error_code_min;
        logic [WORD_W-1:0]  error_code_max;
        logic [COUNT_W-1:0] card_count_max;
    } t_cfg;

endpackage

@@ rtl/csrc_word_if.sv @@
// ----------------------------------------------------------------------------
// csrc_word_if
// Input channel: one report word per transfer.
// ----------------------------------------------------------------------------
interface csrc_word_if;
    logic        valid;
    logic        ready;
    logic [15:0] word;
    logic        first_word;

    modport source (output valid, output word, output first_word, input ready);
    modport sink   (input valid, input word, input first_word, output ready);
endinterface

@@ rtl/csrc_verdict_if.sv @@
// ----------------------------------------------------------------------------
// csrc_verdict_if
// Output channel: one verdict per transfer.
// ----------------------------------------------------------------------------
interface csrc_verdict_if;
    logic        valid;
    logic        ready;
    logic        passed;
    logic [3:0]  fail_reason;
    logic [15:0] bad_word;

    modport source (output valid, output passed, output fail_reason, output bad_word,
                    input ready);
    modport sink   (input valid, input passed, input fail_reason, input bad_word,
                    output ready);
endinterface

@@ rtl/csrc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// csrc_cfg_regs
// APB register file holding the check limits.
// ----------------------------------------------------------------------------
module csrc_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [csrc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [csrc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [csrc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output csrc_pkg::t_cfg                    o_cfg
);
    import csrc_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.carrier_max     <= CAR_W'(4);
            r_cfg.alarm_count_max <= COUNT_W'(255);
            r_cfg.alarm_code_min  <= WORD_W'(221);
            r_cfg.alarm_code_max  <= WORD_W'(255);
            r_cfg.error_count_max <= COUNT_W'(255);
            r_cfg.error_code_min  <= WORD_W'(221);
            r_cfg.error_code_max  <= WORD_W'(255);
            r_cfg.card_count_max  <= COUNT_W'(6);
        end else if (wr_en) begin
            case (reg_idx)
                REG_CARRIER_MAX:     r_cfg.carrier_max     <= pwdata[CAR_W-1:0];
                REG_ALARM_COUNT_MAX: r_cfg.alarm_count_max <= pwdata[COUNT_W-1:0];
                REG_ALARM_CODE_MIN:  r_cfg.alarm_code_min  <= pwdata[WORD_W-1:0];
                REG_ALARM_CODE_MAX:  r_cfg.alarm_code_max  <= pwdata[WORD_W-1:0];
                REG_ERROR_COUNT_MAX: r_cfg.error_count_max <= pwdata[COUNT_W-1:0];
                REG_ERROR_CODE_MIN:  r_cfg.error_code_min  <= pwdata[WORD_W-1:0];
                REG_ERROR_CODE_MAX:  r_cfg.error_code_max  <= pwdata[WORD_W-1:0];
                REG_CARD_COUNT_MAX:  r_cfg.card_count_max  <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CARRIER_MAX:     prdata = APB_DATA_W'(r_cfg.carrier_max);
            REG_ALARM_COUNT_MAX: prdata = APB_DATA_W'(r_cfg.alarm_count_max);
            REG_ALARM_CODE_MIN:  prdata = APB_DATA_W'(r_cfg.alarm_code_min);
            REG_ALARM_CODE_MAX:  prdata = APB_DATA_W'(r_cfg.alarm_code_max);
            REG_ERROR_COUNT_MAX: prdata = APB_DATA_W'(r_cfg.error_count_max);
            REG_ERROR_CODE_MIN:  prdata = APB_DATA_W'(r_cfg.error_code_min);
            REG_ERROR_CODE_MAX:  prdata = APB_DATA_W'(r_cfg.error_code_max);
            REG_CARD_COUNT_MAX:  prdata = APB_DATA_W'(r_cfg.card_count_max);
            default:             prdata = '0;
        endcase
    end

endmodule

@@ rtl/csrc_parser.sv @@
// ----------------------------------------------------------------------------
// csrc_parser
// Input register, message walker and verdict register.
// ----------------------------------------------------------------------------
module csrc_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  csrc_pkg::t_cfg i_cfg,
    csrc_word_if.sink      i_word_ch,
    csrc_verdict_if.source o_verdict_ch
);
    import csrc_pkg::*;

    localparam logic [3:0] PH_WAIT    = 4'd0;
    localparam logic [3:0] PH_CARNO   = 4'd1;
    localparam logic [3:0] PH_STATUS  = 4'd2;
    localparam logic [3:0] PH_CONFIG  = 4'd3;
    localparam logic [3:0] PH_ALMCNT  = 4'd4;
    localparam logic [3:0] PH_ALMCODE = 4'd5;
    localparam logic [3:0] PH_ERRCNT  = 4'd6;
    localparam logic [3:0] PH_ERRCODE = 4'd7;
    localparam logic [3:0] PH_CRDCNT  = 4'd8;
    localparam logic [3:0] PH_CRDSKIP = 4'd9;

    // input register
    logic              r_in_valid;
    logic [WORD_W-1:0] r_in_word;
    logic              r_in_first;

    // walker state
    logic [3:0]         r_phase,    n_phase;
    logic [CAR_W-1:0]   r_car_left, n_car_left;
    logic [COUNT_W-1:0] r_ent_left, n_ent_left;

    // verdict register
    logic                r_out_valid;
    logic                r_passed;
    logic [REASON_W-1:0] r_reason;
    logic [WORD_W-1:0]   r_bad_word;

    logic                emit;
    logic [REASON_W-1:0] reason;
    logic                advance;
    logic [WORD_W-1:0]   w;
    logic [CAR_W-1:0]    car_dec;
    logic [COUNT_W-1:0]  ent_dec;

    assign w       = r_in_word;
    assign car_dec = r_car_left - CAR_W'(1);
    assign ent_dec = r_ent_left - COUNT_W'(1);

    always_comb begin
        n_phase    = r_phase;
        n_car_left = r_car_left;
        n_ent_left = r_ent_left;
        emit       = 1'b0;
        reason     = RSN_NONE;
        if (r_in_first) begin
            if (w > WORD_W'(i_cfg.carrier_max)) begin
                emit   = 1'b1;
                reason = RSN_COUNT;
            end else if (w == '0) begin
                emit = 1'b1;
            end else begin
                n_car_left = w[CAR_W-1:0];
                n_ent_left = '0;
                n_phase    = PH_CARNO;
            end
        end else begin
            case (r_phase)
                PH_CARNO: begin
                    if (w < CARRIER_MIN || w > WORD_W'(i_cfg.carrier_max)) begin
                        emit   = 1'b1;
                        reason = RSN_CARRIER_NO;
                    end else begin
                        n_phase = PH_STATUS;
                    end
                end
                PH_STATUS: n_phase = PH_CONFIG;
                PH_CONFIG: begin
                    if (w > CONFIG_STATE_MAX) begin
                        emit   = 1'b1;
                        reason = RSN_CONFIG;
                    end else begin
                        n_phase = PH_ALMCNT;
                    end
                end
                PH_ALMCNT: begin
                    if (w > WORD_W'(i_cfg.alarm_count_max)) begin
                        emit   = 1'b1;
                        reason = RSN_ALARM_COUNT;
                    end else begin
                        n_ent_left = w[COUNT_W-1:0];
                        n_phase    = (w == '0) ? PH_ERRCNT : PH_ALMCODE;
                    end
                end
                PH_ALMCODE: begin
                    if (w < i_cfg.alarm_code_min || w > i_cfg.alarm_code_max) begin
                        emit   = 1'b1;
                        reason = RSN_ALARM_CODE;
                    end else begin
                        n_ent_left = ent_dec;
                        if (ent_dec == '0) n_phase = PH_ERRCNT;
                    end
                end
                PH_ERRCNT: begin
                    if (w > WORD_W'(i_cfg.error_count_max)) begin
                        emit   = 1'b1;
                        reason = RSN_ERROR_COUNT;
                    end else begin
                        n_ent_left = w[COUNT_W-1:0];
                        n_phase    = (w == '0) ? PH_CRDCNT : PH_ERRCODE;
                    end
                end
                PH_ERRCODE: begin
                    if (w < i_cfg.error_code_min || w > i_cfg.error_code_max) begin
                        emit   = 1'b1;
                        reason = RSN_ERROR_CODE;
                    end else begin
                        n_ent_left = ent_dec;
                        if (ent_dec == '0) n_phase = PH_CRDCNT;
                    end
                end
                PH_CRDCNT: begin
                    if (w > WORD_W'(i_cfg.card_count_max)) begin
                        emit   = 1'b1;
                        reason = RSN_CARD_COUNT;
                    end else if (w == '0) begin
                        // empty card list closes the record
                        n_ent_left = '0;
                        n_car_left = car_dec;
                        n_phase    = PH_CARNO;
                        emit       = (car_dec == '0);
                    end else begin
                        n_ent_left = w[COUNT_W-1:0];
                        n_phase    = PH_CRDSKIP;
                    end
                end
                PH_CRDSKIP: begin
                    n_ent_left = ent_dec;
                    if (ent_dec == '0) begin
                        n_car_left = car_dec;
                        n_phase    = PH_CARNO;
                        emit       = (car_dec == '0);
                    end
                end
                default: ;
            endcase
        end
        // any verdict ends the message
        if (emit) begin
            n_phase    = PH_WAIT;
            n_car_left = '0;
            n_ent_left = '0;
        end
    end

    assign advance         = r_in_valid && (!emit || !r_out_valid || o_verdict_ch.ready);
    assign i_word_ch.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_word_ch.ready) begin
            r_in_valid <= i_word_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_word_ch.ready && i_word_ch.valid) begin
            r_in_word  <= i_word_ch.word;
            r_in_first <= i_word_ch.first_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT;
            r_car_left <= '0;
            r_ent_left <= '0;
        end else if (advance) begin
            r_phase    <= n_phase;
            r_car_left <= n_car_left;
            r_ent_left <= n_ent_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_verdict_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_passed   <= (reason == RSN_NONE);
            r_reason   <= reason;
            r_bad_word <= (reason == RSN_NONE) ? '0 : w;
        end
    end

    assign o_verdict_ch.valid       = r_out_valid;
    assign o_verdict_ch.passed      = r_passed;
    assign o_verdict_ch.fail_reason = r_reason;
    assign o_verdict_ch.bad_word    = r_bad_word;

    // idle exactly when no records are pending
    a_wait_no_carriers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WAIT) == (r_car_left == '0))
        else $error("phase and carrier count disagree");

    // list phases always have entries left
    a_list_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ALMCODE || r_phase == PH_ERRCODE || r_phase == PH_CRDSKIP)
        |-> (r_ent_left != '0))
        else $error("list phase with no entries left");

    // a verdict sends the walker back to idle
    a_verdict_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && emit) |=> (r_phase == PH_WAIT && r_out_valid))
        else $error("verdict did not end the message");

    // pass carries no reason and no word; fail always has a reason
    a_verdict_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_passed ? (r_reason == RSN_NONE && r_bad_word == '0)
                                  : (r_reason != RSN_NONE)))
        else $error("inconsistent verdict fields");

endmodule

@@ rtl/carrier_status_report_checker_top.sv @@
// ----------------------------------------------------------------------------
// carrier_status_report_checker_top
// Checks carrier status report messages word by word and returns one verdict.
// ----------------------------------------------------------------------------
// Usage: feed report words on i_word_ch, one word per transfer, with
// first_word set on the carrier count that opens each message. The block
// takes one word every clock cycle unless the input stalls; words pass an
// input register, the walker logic and the verdict register before a verdict
// shows on o_verdict_ch. A message gives exactly one verdict: passed after
// the last carrier record, or a fail reason and the offending word at the
// first bad word; words after that are dropped until the next first_word.
// A first_word in the middle of a message silently restarts the check. The
// verdict register frees the input while a verdict waits; the input stalls
// only when a second verdict is due before the first is taken. Limits are
// set through the APB registers (byte address 4 * index) and should be
// written only while no message is in progress.
// ----------------------------------------------------------------------------
module carrier_status_report_checker_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [csrc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [csrc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [csrc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // word stream in, verdicts out
    csrc_word_if.sink                         i_word_ch,
    csrc_verdict_if.source                    o_verdict_ch
);
    import csrc_pkg::*;

    t_cfg cfg;

    // limit registers
    csrc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // message walker with input and verdict registers
    csrc_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_word_ch    (i_word_ch),
        .o_verdict_ch (o_verdict_ch)
    );

endmodule
